>>> rtl/cd3_pkg.sv
// cd3_pkg: shared types and constants of the 3x3 color dilation block.
// Used by every module under rtl/ except cd3_ram; depends on nothing.
package cd3_pkg;

  localparam int PIX_W          = 8;
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 13;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EIGHT_CONNECTED = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_COLOR    = 2'd3;

  // input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int FRAME_WIDTH_RST  = 256;
  localparam int FRAME_HEIGHT_RST = 256;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic   command;
    pixel_t pixel_in;
  } in_item_t;

  typedef struct packed {
    pixel_t pixel_out;
    logic   frame_end;
  } out_item_t;

  // one window column: row above, middle row, newest row
  typedef struct packed {
    pixel_t up;
    pixel_t mid;
    pixel_t cur;
  } column_t;

  // which neighbors of the center pixel lie inside the frame
  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
  } border_t;

endpackage

>>> rtl/cd3_ram.sv
// cd3_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module cd3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/cd3_linebuf.sv
// cd3_linebuf: the two line stores packed in one RAM word, read-modify-write per column.
// Depends on cd3_pkg and cd3_ram.
module cd3_linebuf import cd3_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         upd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] upd_addr,
  input  pixel_t                       upd_pix,
  output column_t                      column
);

  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] wr_data;
  logic [2*PIX_W-1:0] fwd_data;
  logic               fwd_hit;

  // word layout: upper line in the high byte, middle line in the low byte
  assign wr_data = {column.mid, upd_pix};

  cd3_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (upd_en),
    .wr_addr (upd_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // read and write-back of the same column on one edge: RAM returns stale data
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= upd_en && (rd_addr == upd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  always_comb begin
    if (fwd_hit) begin
      column.up  = fwd_data[2*PIX_W-1:PIX_W];
      column.mid = fwd_data[PIX_W-1:0];
    end else begin
      column.up  = ram_rdata[2*PIX_W-1:PIX_W];
      column.mid = ram_rdata[PIX_W-1:0];
    end
    column.cur = upd_pix;
  end

endmodule

>>> rtl/cd3_window.sv
// cd3_window: 3x3 window register and the dilation decision for its center.
// Depends on cd3_pkg.
module cd3_window import cd3_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    shift_en,
  input  column_t column,
  input  border_t border,
  input  logic    eight_connected,
  input  pixel_t  target_color,
  output pixel_t  result
);

  column_t win [3];   // 0 left, 1 center, 2 right
  logic    hit_orth;
  logic    hit_diag;

  always_ff @(posedge clk) begin
    if (rst) begin
      win[0] <= '0;
      win[1] <= '0;
      win[2] <= '0;
    end else if (shift_en) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= column;
    end
  end

  always_comb begin
    hit_orth = (win[1].mid == target_color)
             || (border.top && win[1].up  == target_color)
             || (border.bot && win[1].cur == target_color)
             || (border.lft && win[0].mid == target_color)
             || (border.rgt && win[2].mid == target_color);
    hit_diag = (border.top && border.lft && win[0].up  == target_color)
             || (border.top && border.rgt && win[2].up  == target_color)
             || (border.bot && border.lft && win[0].cur == target_color)
             || (border.bot && border.rgt && win[2].cur == target_color);
    result   = (hit_orth || (eight_connected && hit_diag)) ? target_color : win[1].mid;
  end

endmodule

>>> rtl/color_dilation_3x3_core.sv
// color_dilation_3x3_core: streaming 3x3 color dilation over 8-bit palette frames.
// Depends on cd3_pkg, cd3_linebuf, cd3_window.
//
// Pixels enter in raster order, one request per clock. A pixel leaves as
// target_color when it or an in-frame neighbor (four or eight connected, per
// the eight_connected register) equals target_color, else unchanged. The
// first frame_width+1 requests of a frame give no result; after the last
// pixel, drain requests (or further pixels, which are dropped) push the tail
// out, and the result flagged frame_end starts a new frame. A drain while
// frame pixels are still expected is taken and ignored. Throughput is one
// request per cycle while in_stall is low; results pass the line store read,
// the window and the output buffer. The rate is set by the line store: one RAM
// of MAX_WIDTH x 16 bits holding both stored rows, read once and written once
// per cycle, with a forward path when the same column is read and written on
// one edge (frame width 1). Results go through a two-entry output buffer;
// in_stall rises only when both entries are full. The RAM has no clearing pass
// and is usable right after reset. Writing frame_width or frame_height restarts
// the frame; configuration must only be written while no request is in flight.
module color_dilation_3x3_core import cd3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int CW    = $clog2(MAX_WIDTH);       // column
  localparam int HW    = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int RW    = $clog2(MAX_HEIGHT + 2);  // input row runs to height+1
  localparam int OYW   = $clog2(MAX_HEIGHT);      // output row
  localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  // configuration, width and height stored already clamped
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          eight_conn;
  pixel_t        target;
  logic [WW-1:0] w_clamp;
  logic [HW-1:0] h_clamp;
  logic [31:0]   fw_req;
  logic [31:0]   fh_req;
  logic          cfg_restart;

  logic [WW-1:0] w_m1;
  logic [HW-1:0] h_m1;

  // input position
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;

  // request decode
  logic   accept;
  logic   in_frame;
  logic   take;
  logic   col_last;
  logic   frame_last;
  logic   early;
  pixel_t pix_v;

  // stage 1: line store read in flight
  logic          s1_valid;
  logic          s1_emit;
  logic          s1_last;
  pixel_t        s1_pix;
  logic [CW-1:0] s1_col;

  // stage 2: window holds this request's neighborhood
  logic s2_emit;
  logic s2_last;

  // output position
  logic [CW-1:0]  ox;
  logic [OYW-1:0] oy;

  column_t   column;
  border_t   border;
  pixel_t    result;
  out_item_t new_item;

  // output buffer
  logic      adv;
  logic      push;
  logic      pop;
  logic      full;
  logic      skid_valid;
  out_item_t skid_data;

  // ---------------- configuration ----------------
  always_comb begin
    fw_req = 32'(cfg_data[FRAME_WIDTH_W-1:0]);
    fh_req = 32'(cfg_data[FRAME_HEIGHT_W-1:0]);
    if (fw_req == 32'd0) begin
      w_clamp = WW'(1);
    end else if (fw_req > 32'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(fw_req);
    end
    if (fh_req == 32'd0) begin
      h_clamp = HW'(1);
    end else if (fh_req > 32'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(fh_req);
    end
  end

  assign cfg_restart = cfg_write
                    && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff      <= WW'(W_RST);
      h_eff      <= HW'(H_RST);
      eight_conn <= 1'b0;
      target     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:     w_eff      <= w_clamp;
        REG_FRAME_HEIGHT:    h_eff      <= h_clamp;
        REG_EIGHT_CONNECTED: eight_conn <= cfg_data[0];
        REG_TARGET_COLOR:    target     <= cfg_data[PIX_W-1:0];
      endcase
    end
  end

  assign w_m1 = w_eff - WW'(1);
  assign h_m1 = h_eff - HW'(1);

  // ---------------- input side ----------------
  assign full     = out_valid && skid_valid;
  assign adv      = !full;
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  assign in_frame = in_row < RW'(h_eff);
  // a drain during the frame body is swallowed without effect
  assign take     = accept && !(in_frame && in_data.command == CMD_DRAIN);
  assign pix_v    = in_frame ? in_data.pixel_in : '0;

  assign col_last   = in_col == w_m1[CW-1:0];
  // last output pixel of the frame is due at row height+1, column 0
  assign frame_last = (in_row == RW'(h_eff) + RW'(1)) && (in_col == '0);
  // nothing to emit before one row plus one pixel has gone in
  assign early      = (in_row == '0) || ((in_row == RW'(1)) && (in_col == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
    end else if (cfg_restart) begin
      in_col <= '0;
      in_row <= '0;
    end else if (take) begin
      if (frame_last) begin
        in_col <= '0;
        in_row <= '0;
      end else if (col_last) begin
        in_col <= '0;
        in_row <= in_row + RW'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
    end
  end

  // ---------------- pipeline ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_emit  <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
      s2_emit  <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix  <= pix_v;
      s1_col  <= in_col;
      s1_emit <= !early;
      s1_last <= frame_last;
    end
    if (adv) begin
      s2_last <= s1_last;
    end
  end

  cd3_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (take),
    .rd_addr  (in_col),
    .upd_en   (adv && s1_valid),
    .upd_addr (s1_col),
    .upd_pix  (s1_pix),
    .column   (column)
  );

  // frame edges seen from the output pixel
  assign border.top = oy != '0;
  assign border.bot = oy != OYW'(h_m1);
  assign border.lft = ox != '0;
  assign border.rgt = ox != w_m1[CW-1:0];

  cd3_window u_window (
    .clk             (clk),
    .rst             (rst),
    .shift_en        (adv && s1_valid),
    .column          (column),
    .border          (border),
    .eight_connected (eight_conn),
    .target_color    (target),
    .result          (result)
  );

  assign push = adv && s2_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      ox <= '0;
      oy <= '0;
    end else if (cfg_restart) begin
      ox <= '0;
      oy <= '0;
    end else if (push) begin
      if (s2_last) begin
        ox <= '0;
        oy <= '0;
      end else if (ox == w_m1[CW-1:0]) begin
        ox <= '0;
        oy <= oy + OYW'(1);
      end else begin
        ox <= ox + CW'(1);
      end
    end
  end

  // ---------------- output buffer ----------------
  assign new_item.pixel_out = result;
  assign new_item.frame_end = s2_last;
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      // push cannot meet a full buffer here: full blocks adv
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (pop || !out_valid)) begin
      out_data <= new_item;
    end
    if (push && out_valid && !pop) begin
      skid_data <= new_item;
    end
  end

endmodule

>>> rtl/cd3_checker.sv
// cd3_checker: port-level assertions for color_dilation_3x3_core, bound to the top level.
// Depends on cd3_pkg.
module cd3_checker import cd3_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result shown after reset");

  // requests are held back only while results are waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // the buffer fills only while the consumer holds off
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without output stall");

endmodule

bind color_dilation_3x3_core cd3_checker u_cd3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
